// File: hdl/eps_pkg.sv
// Package for the periodic task scheduler: sizes, register indexes,
// shared types. No dependencies.
`default_nettype none

package eps_pkg;

  localparam int NUM_TASKS  = 4;
  localparam int TIME_WIDTH = 32;

  localparam int EXEC_W     = 16;
  localparam int TICK_W     = 32;
  localparam int TASK_W     = 2;
  localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXEC_TIMES = 2'd0,
    CFG_PERIODS    = 2'd1,
    CFG_TASK_COUNT = 2'd2
  } cfg_reg_t;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [EXEC_W-1:0]     exec_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

`default_nettype wire

// File: hdl/eps_if.sv
// Handshake interfaces for the scheduler's tick and result words.
// Uses no package.
`default_nettype none

interface eps_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface eps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_time;
  logic [1:0]  running_task;
  logic        idle;
  logic        missed;
  logic [1:0]  missed_task;
  logic [15:0] missed_remaining;
  logic        halted;
  logic        time_overflow;

  modport source (output valid, output tick_time, output running_task, output idle,
                  output missed, output missed_task, output missed_remaining,
                  output halted, output time_overflow, input ready);
  modport sink   (input valid, input tick_time, input running_task, input idle,
                  input missed, input missed_task, input missed_remaining,
                  input halted, input time_overflow, output ready);
endinterface

`default_nettype wire

// File: hdl/edf_periodic_task_scheduler_core.sv
// Periodic task scheduler, earliest deadline first: takes tick words and
// gives a result word for each. Depends on eps_pkg, eps_if and eps_pick.
//
// Each accepted word is one time tick. The word lands in an input register;
// when the output register is free or being read, the release, deadline-miss,
// selection and re-arm logic runs on the task state and the result goes into
// the output register. The block sustains one word per cycle while results
// are taken; the combinational task state update loop (release, miss check,
// four-way deadline compare, re-arm) sets that rate. The output register
// lets a tick be accepted while a result waits. Registers: 0 execution
// times, 1 periods, 2 task count. After reset all deadlines are zero, so
// the first tick reports a miss of task 0.
`default_nettype none

module edf_periodic_task_scheduler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  eps_in_if.sink                           in_ch,
  eps_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import eps_pkg::*;

  typedef struct packed {
    logic [TICK_W-1:0] tick_time;
    logic [TASK_W-1:0] running_task;
    logic              idle;
    logic              missed;
    logic [TASK_W-1:0] missed_task;
    exec_t             missed_remaining;
    logic              halted;
    logic              time_overflow;
  } res_t;

  // config
  logic [CFG_DATA_W-1:0] exec_times_r;
  logic [CFG_DATA_W-1:0] periods_r;
  logic [CNT_W-1:0]      task_count_r;

  // input stage
  logic s1_valid_r;
  logic s1_restart_r;
  logic fire;

  // task state
  time_t                time_now_r, time_now_nxt;
  time_t                deadline_r [NUM_TASKS];
  time_t                deadline_nxt [NUM_TASKS];
  time_t                release_r [NUM_TASKS];
  time_t                release_nxt [NUM_TASKS];
  exec_t                remain_r [NUM_TASKS];
  exec_t                remain_nxt [NUM_TASKS];
  logic [NUM_TASKS-1:0] ready_r, ready_nxt;
  logic                 stopped_r, stopped_nxt;

  // effective state after an optional restart
  time_t                t_eff;
  time_t                deadline_eff [NUM_TASKS];
  time_t                release_eff [NUM_TASKS];
  exec_t                remain_eff [NUM_TASKS];
  logic [NUM_TASKS-1:0] ready_eff;
  logic                 stopped_eff;

  logic [CNT_W-1:0]     n_use;
  logic [NUM_TASKS-1:0] active;
  logic [NUM_TASKS-1:0] ready_rel;
  logic                 miss_seen;
  logic [IDX_W-1:0]     miss_idx;
  logic                 at_max;
  pick_t                pick;

  logic              out_valid_r;
  res_t              res_r, res_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_times_r <= '0;
      periods_r    <= '0;
      task_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXEC_TIMES: exec_times_r <= cfg_wdata;
        CFG_PERIODS:    periods_r    <= cfg_wdata;
        CFG_TASK_COUNT: task_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign fire        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_restart_r <= in_ch.restart;
    end
  end

  // restart reloads from the current registers
  always_comb begin
    for (int k = 0; k < NUM_TASKS; k++) begin
      if (s1_restart_r) begin
        deadline_eff[k] = time_t'(periods_r[EXEC_W*k +: EXEC_W]);
        release_eff[k]  = '0;
        remain_eff[k]   = exec_times_r[EXEC_W*k +: EXEC_W];
      end else begin
        deadline_eff[k] = deadline_r[k];
        release_eff[k]  = release_r[k];
        remain_eff[k]   = remain_r[k];
      end
    end
    ready_eff   = s1_restart_r ? '1 : ready_r;
    t_eff       = s1_restart_r ? '0 : time_now_r;
    stopped_eff = s1_restart_r ? 1'b0 : stopped_r;
  end

  always_comb begin
    if (task_count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (task_count_r > CNT_W'(NUM_TASKS)) begin
      n_use = CNT_W'(NUM_TASKS);
    end else begin
      n_use = task_count_r;
    end
    for (int k = 0; k < NUM_TASKS; k++) begin
      active[k] = CNT_W'(k) < n_use;
    end
  end

  assign at_max = (t_eff == '1);

  // release in index order, stopping after the first miss
  always_comb begin
    miss_seen = 1'b0;
    miss_idx  = '0;
    ready_rel = ready_eff;
    for (int k = 0; k < NUM_TASKS; k++) begin
      if (!miss_seen && active[k] && release_eff[k] == t_eff) begin
        ready_rel[k] = 1'b1;
      end
      if (!miss_seen && active[k] && deadline_eff[k] == t_eff) begin
        miss_seen = 1'b1;
        miss_idx  = IDX_W'(k);
      end
    end
  end

  eps_pick u_pick (
    .cand_i     (ready_rel & active),
    .deadline_i (deadline_eff),
    .pick_o     (pick)
  );

  always_comb begin
    logic [TIME_WIDTH:0] dl_sum;
    exec_t               per;
    time_now_nxt = t_eff;
    deadline_nxt = deadline_eff;
    release_nxt  = release_eff;
    remain_nxt   = remain_eff;
    ready_nxt    = ready_eff;
    stopped_nxt  = stopped_eff;
    dl_sum       = '0;
    per          = '0;

    res_nxt           = '0;
    res_nxt.tick_time = TICK_W'(t_eff);
    res_nxt.idle      = 1'b1;

    priority if (stopped_eff) begin
      res_nxt.halted = 1'b1;
    end else if (at_max) begin
      stopped_nxt           = 1'b1;
      res_nxt.halted        = 1'b1;
      res_nxt.time_overflow = 1'b1;
    end else if (miss_seen) begin
      stopped_nxt              = 1'b1;
      ready_nxt                = ready_rel;
      res_nxt.halted           = 1'b1;
      res_nxt.missed           = 1'b1;
      res_nxt.missed_task      = TASK_W'(miss_idx);
      res_nxt.missed_remaining = remain_eff[miss_idx];
    end else begin
      ready_nxt    = ready_rel;
      time_now_nxt = t_eff + time_t'(1);
      if (pick.found) begin
        res_nxt.idle         = 1'b0;
        res_nxt.running_task = TASK_W'(pick.idx);
        if (remain_eff[pick.idx] <= exec_t'(1)) begin
          per    = periods_r[EXEC_W*pick.idx +: EXEC_W];
          dl_sum = {1'b0, deadline_eff[pick.idx]} + (TIME_WIDTH+1)'(per);
          release_nxt[pick.idx]  = deadline_eff[pick.idx];
          deadline_nxt[pick.idx] = dl_sum[TIME_WIDTH] ? '1 : dl_sum[TIME_WIDTH-1:0];
          remain_nxt[pick.idx]   = exec_times_r[EXEC_W*pick.idx +: EXEC_W];
          ready_nxt[pick.idx]    = 1'b0;
        end else begin
          remain_nxt[pick.idx] = remain_eff[pick.idx] - exec_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r <= '0;
      stopped_r  <= 1'b0;
      ready_r    <= '1;
      for (int k = 0; k < NUM_TASKS; k++) begin
        deadline_r[k] <= '0;
        release_r[k]  <= '0;
        remain_r[k]   <= '0;
      end
    end else if (fire) begin
      time_now_r <= time_now_nxt;
      stopped_r  <= stopped_nxt;
      ready_r    <= ready_nxt;
      deadline_r <= deadline_nxt;
      release_r  <= release_nxt;
      remain_r   <= remain_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.tick_time        = res_r.tick_time;
  assign out_ch.running_task     = res_r.running_task;
  assign out_ch.idle             = res_r.idle;
  assign out_ch.missed           = res_r.missed;
  assign out_ch.missed_task      = res_r.missed_task;
  assign out_ch.missed_remaining = res_r.missed_remaining;
  assign out_ch.halted           = res_r.halted;
  assign out_ch.time_overflow    = res_r.time_overflow;

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res_nxt.missed || res_nxt.time_overflow) |=> stopped_r)
    else $error("miss or overflow did not halt");

  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res_nxt.halted |=> time_now_r == $past(t_eff) + time_t'(1))
    else $error("time did not advance on a running tick");

  a_run_not_halt: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res_nxt.idle |-> !res_nxt.halted && !res_nxt.missed)
    else $error("task granted on a halted tick");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !fire |=> s1_valid_r)
    else $error("tick word dropped in input stage");
`endif

endmodule

`default_nettype wire

// File: hdl/eps_pick.sv
// Earliest-deadline selection among candidate tasks, lower index wins ties.
// Depends on eps_pkg.
`default_nettype none

module eps_pick (
  input  logic [eps_pkg::NUM_TASKS-1:0] cand_i,
  input  eps_pkg::time_t                deadline_i [eps_pkg::NUM_TASKS],
  output eps_pkg::pick_t                pick_o
);
  import eps_pkg::*;

  always_comb begin
    time_t best_dl;
    pick_o  = '0;
    best_dl = '0;
    for (int k = 0; k < NUM_TASKS; k++) begin
      if (cand_i[k] && (!pick_o.found || deadline_i[k] < best_dl)) begin
        pick_o.found = 1'b1;
        pick_o.idx   = IDX_W'(k);
        best_dl      = deadline_i[k];
      end
    end
  end

endmodule

`default_nettype wire
